FILE: design/segment_box_slab_intersect_core_macros.svh
// assertion macros for the segment box slab intersect checker
// depends on nothing; included by the checker file
`ifndef SEGMENT_BOX_SLAB_INTERSECT_CORE_MACROS_SVH
`define SEGMENT_BOX_SLAB_INTERSECT_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define SBSI_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");

// next-cycle implication checked outside reset
`define SBSI_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");

`endif

FILE: design/sbsi_pkg.sv
// shared types and constants for the segment box slab intersect core
// depends on nothing
package sbsi_pkg;

   localparam int CoordWidth = 16;
   localparam int FracBits   = 16;
   localparam int TimeWidth  = FracBits + 1;
   // axis delta fits in one more bit than a coordinate
   localparam int DistWidth  = CoordWidth + 1;
   // number of quotient steps in one restoring divider
   localparam int DivSteps   = FracBits + 1;

   localparam logic [TimeWidth-1:0] TimeOne = TimeWidth'(1) << FracBits;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic [DistWidth-1:0]         dist_type;
   typedef logic [TimeWidth-1:0]         time_type;

   // per-axis setup: which quotients are needed and their operands
   typedef struct packed {
      logic     miss;
      logic     need_in;
      logic     need_out;
      dist_type num_in;
      dist_type num_out;
      dist_type den;
   } axis_setup_type;

endpackage

FILE: design/segment_box_slab_intersect_core.sv
// top level of the segment box slab intersect core
// depends on sbsi_pkg and sbsi_divider
//
// channel   direction  handshake           payload
// req_      in         start, busy         segment ends, box corners
// rsp_      out        rsp_valid strobe    hit, entry_time
//
// one item per cycle; the result strobe passes through the setup register,
// the divider load, one quotient bit per divider stage (four dividers side
// by side), then the output register
// reset clears all valid bits; busy stays low, results cannot be stalled
module segment_box_slab_intersect_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sbsi_pkg::coord_type req_start_x,
   input  sbsi_pkg::coord_type req_start_y,
   input  sbsi_pkg::coord_type req_end_x,
   input  sbsi_pkg::coord_type req_end_y,
   input  sbsi_pkg::coord_type req_box_min_x,
   input  sbsi_pkg::coord_type req_box_min_y,
   input  sbsi_pkg::coord_type req_box_max_x,
   input  sbsi_pkg::coord_type req_box_max_y,
   output logic                rsp_valid,
   output logic                rsp_hit,
   output sbsi_pkg::time_type  rsp_entry_time
);

   localparam int N = sbsi_pkg::DivSteps;

   assign busy = 1'b0;

   // axis setup: side tests and quotient operands
   function automatic sbsi_pkg::axis_setup_type setup(
      sbsi_pkg::coord_type s, sbsi_pkg::coord_type e,
      sbsi_pkg::coord_type lo, sbsi_pkg::coord_type hi);
      sbsi_pkg::axis_setup_type r;
      r = '0;
      if (s < e) begin
         r.den      = sbsi_pkg::DistWidth'(e) - sbsi_pkg::DistWidth'(s);
         r.miss     = (s > hi) || (e < lo);
         r.need_in  = s < lo;
         r.num_in   = sbsi_pkg::DistWidth'(lo) - sbsi_pkg::DistWidth'(s);
         r.need_out = e > hi;
         r.num_out  = sbsi_pkg::DistWidth'(hi) - sbsi_pkg::DistWidth'(s);
      end else begin
         r.den      = sbsi_pkg::DistWidth'(s) - sbsi_pkg::DistWidth'(e);
         r.miss     = (e > hi) || (s < lo);
         r.need_in  = s > hi;
         r.num_in   = sbsi_pkg::DistWidth'(s) - sbsi_pkg::DistWidth'(hi);
         r.need_out = e < lo;
         r.num_out  = sbsi_pkg::DistWidth'(s) - sbsi_pkg::DistWidth'(lo);
      end
      return r;
   endfunction

   // stage one: registered setup for both axes
   logic                     s1_valid_ff;
   sbsi_pkg::axis_setup_type s1_x_ff, s1_y_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start;
   end

   always_ff @(posedge clock) begin
      s1_x_ff <= setup(req_start_x, req_end_x, req_box_min_x, req_box_max_x);
      s1_y_ff <= setup(req_start_y, req_end_y, req_box_min_y, req_box_max_y);
   end

   // four dividers run in lockstep
   sbsi_pkg::time_type q_xin, q_xout, q_yin, q_yout;

   sbsi_divider u_div_xin  (.clock, .advance(1'b1), .num(s1_x_ff.num_in),
                            .den(s1_x_ff.den), .quot(q_xin));
   sbsi_divider u_div_xout (.clock, .advance(1'b1), .num(s1_x_ff.num_out),
                            .den(s1_x_ff.den), .quot(q_xout));
   sbsi_divider u_div_yin  (.clock, .advance(1'b1), .num(s1_y_ff.num_in),
                            .den(s1_y_ff.den), .quot(q_yin));
   sbsi_divider u_div_yout (.clock, .advance(1'b1), .num(s1_y_ff.num_out),
                            .den(s1_y_ff.den), .quot(q_yout));

   // side flags travel beside the dividers
   logic       dl_valid_ff [N+1];
   logic [5:0] dl_flag_ff  [N+1];

   always_ff @(posedge clock) begin
      if (reset) dl_valid_ff[0] <= 1'b0;
      else       dl_valid_ff[0] <= s1_valid_ff;
      dl_flag_ff[0] <= {s1_x_ff.miss, s1_x_ff.need_in, s1_x_ff.need_out,
                        s1_y_ff.miss, s1_y_ff.need_in, s1_y_ff.need_out};
   end

   for (genvar i = 0; i < N; i++) begin : g_delay
      always_ff @(posedge clock) begin
         if (reset) dl_valid_ff[i+1] <= 1'b0;
         else       dl_valid_ff[i+1] <= dl_valid_ff[i];
         dl_flag_ff[i+1] <= dl_flag_ff[i];
      end
   end

   // window merge: x axis first, then y axis
   sbsi_pkg::time_type tx_in, tx_out, ty_in, ty_out;
   sbsi_pkg::time_type wx_in, wx_out, wy_in, wy_out;
   logic               miss_x, miss_y, hit_in;
   logic [5:0]         fl;

   always_comb begin
      fl     = dl_flag_ff[N];
      tx_in  = fl[4] ? q_xin  : '0;
      tx_out = fl[3] ? q_xout : sbsi_pkg::TimeOne;
      ty_in  = fl[1] ? q_yin  : '0;
      ty_out = fl[0] ? q_yout : sbsi_pkg::TimeOne;
      wx_in  = tx_in;
      wx_out = tx_out;
      miss_x = fl[5] || (wx_out < wx_in);
      wy_in  = (ty_in > wx_in) ? ty_in : wx_in;
      wy_out = (ty_out < wx_out) ? ty_out : wx_out;
      miss_y = fl[2] || (wy_out < wy_in);
      hit_in = !miss_x && !miss_y;
   end

   // output register
   logic               out_valid_ff, out_hit_ff;
   sbsi_pkg::time_type out_time_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= dl_valid_ff[N];
      out_hit_ff  <= hit_in;
      out_time_ff <= hit_in ? wy_in : '0;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hit        = out_hit_ff;
   assign rsp_entry_time = out_time_ff;

endmodule

FILE: design/sbsi_divider.sv
// pipelined restoring divider: num << FracBits / den, one quotient bit a stage
// depends on sbsi_pkg; num <= den, den > 0 when the result is used
module sbsi_divider (
   input  logic                clock,
   input  logic                advance,
   input  sbsi_pkg::dist_type  num,
   input  sbsi_pkg::dist_type  den,
   output sbsi_pkg::time_type  quot
);

   localparam int N = sbsi_pkg::DivSteps;
   localparam int W = sbsi_pkg::DistWidth + 1;

   logic [W-1:0]                      rem_ff [N+1];
   logic [W-1:0]                      rem_in [N];
   sbsi_pkg::dist_type                den_ff [N+1];
   logic [sbsi_pkg::TimeWidth-1:0]    q_ff   [N+1];
   logic [sbsi_pkg::TimeWidth-1:0]    q_in   [N];

   // stage zero loads operands
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= W'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
      end
   end

   // one quotient bit per stage, msb first
   for (genvar i = 0; i < N; i++) begin : g_step
      always_comb begin
         logic [W-1:0] trial;
         trial = rem_ff[i] - W'(den_ff[i]);
         if (!trial[W-1]) begin
            rem_in[i] = trial << 1;
            q_in[i]   = {q_ff[i][sbsi_pkg::TimeWidth-2:0], 1'b1};
         end else begin
            rem_in[i] = rem_ff[i] << 1;
            q_in[i]   = {q_ff[i][sbsi_pkg::TimeWidth-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1] <= rem_in[i];
            den_ff[i+1] <= den_ff[i];
            q_ff[i+1]   <= q_in[i];
         end
      end
   end

   assign quot = q_ff[N];

endmodule

FILE: design/sbsi_checker.sv
// port-level checks for the segment box slab intersect core
// depends on sbsi_pkg and the macros header
`include "segment_box_slab_intersect_core_macros.svh"

module sbsi_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_hit,
   input sbsi_pkg::time_type rsp_entry_time
);

   // a miss reports zero entry time
   `SBSI_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_entry_time == '0)
   // entry time never exceeds one
   `SBSI_ASSERT_IMPLY(a_time_range, clock, reset, rsp_valid, rsp_entry_time <= sbsi_pkg::TimeOne)
   // the pipeline never stalls the requester
   `SBSI_ASSERT_IMPLY(a_no_busy, clock, reset, 1'b1, !busy)
   // no result appears right after reset without an item
   `SBSI_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind segment_box_slab_intersect_core sbsi_checker u_sbsi_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_hit, .rsp_entry_time
);
